[hw/rtl/mwdf_pkg.sv]
// Package for the multichannel window decision filter.
// Sizes, operation codes and shared types. No dependencies.
package mwdf_pkg;
  localparam int unsigned WinLen   = 8;
  localparam int unsigned Channels = 4;
  localparam int unsigned DataW    = 24;
  localparam int unsigned ChW      = 2;
  localparam int unsigned SlotW    = $clog2(WinLen);
  localparam int unsigned ChIdxW   = (Channels > 1) ? $clog2(Channels) : 1;
  localparam int unsigned Depth    = WinLen * Channels;
  localparam int unsigned AddrW    = $clog2(Depth);
  localparam int unsigned SumW     = DataW + $clog2(WinLen) + 1;
  localparam int unsigned CntW     = $clog2(WinLen + 1);
  localparam int unsigned ThrW     = 16;
  localparam logic [ThrW-1:0] ThrReset = 16'd26;

  // Reciprocal constants for the truncating divides by WinLen-2 and WinLen.
  // Rounded up; exact for every magnitude a window sum can reach.
  localparam int unsigned RecipShift = SumW + 3;
  localparam int unsigned RecipW     = RecipShift + 1;
  localparam logic [RecipW-1:0] TrimMul =
    RecipW'(((64'd1 << RecipShift) + 64'(WinLen - 3)) / 64'(WinLen - 2));
  localparam logic [RecipW-1:0] MeanMul =
    RecipW'(((64'd1 << RecipShift) + 64'(WinLen - 1)) / 64'(WinLen));

  localparam logic [2:0] OpTrim   = 3'd0;
  localparam logic [2:0] OpMode   = 3'd1;
  localparam logic [2:0] OpMedian = 3'd2;
  localparam logic [2:0] OpSmooth = 3'd3;
  localparam logic [2:0] OpMax    = 3'd4;
  localparam logic [2:0] OpMin    = 3'd5;
endpackage

[hw/rtl/mwdf_core.sv]
// Sequenced scan engine over one channel window held in a local register copy.
// Depends on mwdf_pkg.
module mwdf_core import mwdf_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic [2:0]              op_i,
  input  logic [ThrW-1:0]         thr_i,
  input  logic signed [DataW-1:0] win_i [WinLen],
  output logic                    done_o,
  output logic signed [DataW-1:0] res_o
);
  typedef enum logic [2:0] {
    S_IDLE, S_STATS, S_PAIR, S_DIV, S_QUO, S_FIN
  } state_e;

  localparam int unsigned LimW  = SumW + ThrW + 1;
  localparam int unsigned ProdW = SumW + RecipW;

  state_e state_q;
  logic signed [DataW-1:0] w_q [WinLen];
  logic [2:0]              op_q;
  logic [SlotW-1:0]        i_q, j_q;
  logic signed [SumW-1:0]  sum_q;
  logic signed [DataW-1:0] mx_q, mn_q, pick_q;
  logic [CntW-1:0]         c_q, best_q;
  logic signed [SumW-1:0]  num_q, quo_q;
  logic signed [DataW-1:0] held_q;
  logic signed [DataW-1:0] res_q;
  logic                    done_q;
  logic [ProdW-1:0]        prod_q;
  logic                    neg_q;
  logic [SumW-1:0]         mag, qmag;

  // Shared compare unit: element i against element j
  logic signed [DataW-1:0] a, b;
  logic eq, lt;
  assign a  = w_q[i_q];
  assign b  = w_q[j_q];
  assign eq = (a == b);
  assign lt = (b < a);

  localparam logic [SlotW-1:0] LastS = SlotW'(WinLen - 1);
  localparam logic [SlotW-1:0] MidS  = SlotW'(WinLen / 2);

  // Magnitude in, truncated quotient magnitude out of the reciprocal product
  assign mag  = $unsigned(num_q[SumW-1] ? -num_q : num_q);
  assign qmag = SumW'(prod_q >> RecipShift);

  // Smooth test, from registered mean
  logic signed [LimW-1:0] lim, dmx, dmn;
  assign lim = LimW'($signed({1'b0, thr_i})) * LimW'(quo_q);
  assign dmx = (LimW'(mx_q) - LimW'(quo_q)) <<< 8;
  assign dmn = (LimW'(quo_q) - LimW'(mn_q)) <<< 8;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
      held_q  <= '0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (start_i) begin
            w_q   <= win_i;
            op_q  <= op_i;
            i_q   <= '0;
            j_q   <= '0;
            sum_q <= '0;
            mx_q  <= win_i[0];
            mn_q  <= win_i[0];
            c_q   <= '0;
            best_q <= '0;
            pick_q <= win_i[0];
            state_q <= S_STATS;
          end
        end
        // One element a cycle: sum, max, min
        S_STATS: begin
          sum_q <= sum_q + SumW'(b);
          if (b > mx_q) mx_q <= b;
          if (b < mn_q) mn_q <= b;
          if (j_q == LastS) begin
            if (op_q == OpMode || op_q == OpMedian) begin
              i_q <= '0; j_q <= '0; state_q <= S_PAIR;
            end else begin
              num_q <= (op_q == OpTrim) ? sum_q + SumW'(b) - SumW'(mx_q > b ? mx_q : b)
                                         - SumW'(mn_q < b ? mn_q : b)
                                       : sum_q + SumW'(b);
              state_q <= S_DIV;
            end
          end else j_q <= j_q + 1'b1;
        end
        // One pair a cycle: mode counts j>=i, median rank counts all j
        S_PAIR: begin
          logic [CntW-1:0] cn;
          logic hit;
          hit = (op_q == OpMode) ? (j_q >= i_q && eq)
                                 : (lt || (eq && j_q < i_q));
          cn = c_q + CntW'(hit);
          if (j_q == LastS) begin
            c_q <= '0;
            if (op_q == OpMode) begin
              if (cn > best_q) begin best_q <= cn; pick_q <= a; end
            end else if (cn == CntW'(MidS)) pick_q <= a;
            if (i_q == LastS) state_q <= S_FIN;
            else i_q <= i_q + 1'b1;
            j_q <= '0;
          end else begin
            c_q <= cn;
            j_q <= j_q + 1'b1;
          end
        end
        // Constant divide: multiply the magnitude by the rounded-up reciprocal
        S_DIV: begin
          prod_q  <= ProdW'(mag) * ProdW'((op_q == OpTrim) ? TrimMul : MeanMul);
          neg_q   <= num_q[SumW-1];
          state_q <= S_QUO;
        end
        // Restore the sign, truncating toward zero
        S_QUO: begin
          quo_q   <= neg_q ? -$signed(qmag) : $signed(qmag);
          state_q <= S_FIN;
        end
        default: begin
          case (op_q)
            OpTrim:   res_q <= DataW'(quo_q);
            OpMode, OpMedian: res_q <= pick_q;
            OpSmooth: begin
              if (quo_q > 0 && dmx < lim && dmn < lim) begin
                held_q <= DataW'(quo_q);
                res_q  <= DataW'(quo_q);
              end else res_q <= held_q;
            end
            OpMax:    res_q <= mx_q;
            OpMin:    res_q <= mn_q;
            default:  res_q <= '0;
          endcase
          done_q  <= 1'b1;
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;
endmodule

[hw/rtl/multichannel_window_decision_filter_unit.sv]
// Top level of the multichannel window decision filter.
// Depends on mwdf_pkg and mwdf_core.
//  channel | signals                                   | direction
//  input   | in_valid_i/in_ready_o, sample/channel/op   | in
//  output  | out_valid_o/out_ready_i, decided_value     | out
//  config  | cfg_we_i, cfg_wdata_i                      | in
// The result beat for trim, smooth, max, min and the zero codes follows the
// stats walk and the divide and quotient steps, and for mode and median the
// stats walk and the pair walk: the sequencer walks the window one element
// or one pair per cycle. The next input beat is taken only after the result
// beat has left the output register and the engine has returned to idle.
// Reset clears all windows, pointers and the held smooth value at once.
// A finished result holds in the output register; the next beat is taken
// only once the engine is free.
module multichannel_window_decision_filter_unit import mwdf_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [ThrW-1:0]         cfg_wdata_i,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic signed [DataW-1:0] sample_i,
  input  logic [ChW-1:0]          channel_i,
  input  logic [2:0]              op_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic signed [DataW-1:0] decided_value_o
);
  logic [ThrW-1:0] thr_q;
  logic signed [DataW-1:0] win_q [Channels][WinLen];
  logic [SlotW-1:0] ptr_q [Channels];
  logic busy_q, ov_q;
  logic signed [DataW-1:0] out_q;
  logic [ChIdxW-1:0] ch;
  logic [ChW-1:0] ch_fold;
  logic signed [DataW-1:0] nwin [WinLen];
  logic done;
  logic signed [DataW-1:0] res;
  logic acc;
  logic done_seen_q;

  // Fold the channel number into range by repeated constant subtraction
  always_comb begin
    ch_fold = channel_i;
    for (int k = 0; k < (1 << ChW); k++)
      if (32'(ch_fold) >= Channels) ch_fold = ch_fold - ChW'(Channels);
  end
  assign ch = ChIdxW'(ch_fold);
  assign in_ready_o = !busy_q;
  assign acc = in_valid_i && in_ready_o;

  // Window with the new sample placed
  always_comb begin
    for (int k = 0; k < WinLen; k++)
      nwin[k] = (SlotW'(k) == ptr_q[ch]) ? sample_i : win_q[ch][k];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q  <= ThrReset;
      busy_q <= 1'b0;
      ov_q   <= 1'b0;
      for (int c = 0; c < Channels; c++) begin
        ptr_q[c] <= '0;
        for (int k = 0; k < WinLen; k++) win_q[c][k] <= '0;
      end
    end else begin
      if (cfg_we_i) thr_q <= cfg_wdata_i;
      if (acc) begin
        busy_q <= 1'b1;
        win_q[ch] <= nwin;
        ptr_q[ch] <= (ptr_q[ch] == SlotW'(WinLen - 1)) ? '0 : ptr_q[ch] + 1'b1;
      end
      // Drop the beat once taken; release the engine when output is free
      if (done) begin ov_q <= 1'b1; out_q <= res; end
      else if (ov_q && out_ready_i) ov_q <= 1'b0;
      if (busy_q && !ov_q && !done && done_seen_q) busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) done_seen_q <= 1'b0;
    else if (acc) done_seen_q <= 1'b0;
    else if (done) done_seen_q <= 1'b1;
  end

  mwdf_core u_core (
    .clk_i, .rst_ni, .start_i(acc), .op_i, .thr_i(thr_q),
    .win_i(nwin), .done_o(done), .res_o(res)
  );

  assign out_valid_o     = ov_q;
  assign decided_value_o = out_q;
endmodule

[hw/rtl/mwdf_checker.sv]
// Port-level checker for the decision filter, bound to the top level.
// Depends on mwdf_pkg.
module mwdf_checker import mwdf_pkg::*; (
  input logic clk_i, rst_ni, in_valid_i, in_ready_o, out_valid_o, out_ready_i,
  input logic signed [DataW-1:0] decided_value_o
);
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o) else $error("accepted while busy");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(decided_value_o))
    else $error("result dropped");
  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o) else $error("ready with pending result");
endmodule

bind multichannel_window_decision_filter_unit mwdf_checker u_chk (.*);

[verif/multichannel_window_decision_filter_unit_tb.sv]
// Testbench for the multichannel window decision filter unit.
// Drives sample beats and threshold writes, predicts each decided value and
// checks it in a small scoreboard class. Depends on mwdf_pkg and the RTL.
`timescale 1ns / 1ps

module multichannel_window_decision_filter_unit_tb;
  import mwdf_pkg::*;

  localparam int unsigned OpNone = 6;
  localparam int unsigned OpZero = 7;
  localparam longint unsigned CycleLimit = 2_000_000;

  typedef logic signed [DataW-1:0] sample_t;

  // Predict decided values and compare them with the output beats
  class decision_scoreboard;
    sample_t         windows[Channels][WinLen];
    int unsigned     wr_slot[Channels];
    sample_t         held_smooth;
    logic [ThrW-1:0] threshold;
    sample_t         pending_values[$];
    int unsigned     mismatches;

    function void clear_state();
      foreach (windows[c, s]) windows[c][s] = '0;
      foreach (wr_slot[c]) wr_slot[c] = 0;
      held_smooth = '0;
      threshold   = ThrReset;
      pending_values.delete();
      mismatches  = 0;
    endfunction

    // Write the sample into its window, then decide over the whole window
    function void note_sample(sample_t smp, logic [ChW-1:0] ch, logic [2:0] op);
      int unsigned c;
      longint      total, hi, lo, mean, lim, best, cnt;
      sample_t     w[WinLen];
      sample_t     tmp;
      sample_t     res;
      int unsigned pick;
      c = ch % Channels;
      windows[c][wr_slot[c]] = smp;
      wr_slot[c] = (wr_slot[c] + 1) % WinLen;
      w = windows[c];
      total = 0;
      hi = w[0];
      lo = w[0];
      foreach (w[i]) begin
        total += w[i];
        if (w[i] > hi) hi = w[i];
        if (w[i] < lo) lo = w[i];
      end
      res = '0;
      case (op)
        OpTrim: res = sample_t'((total - hi - lo) / longint'(WinLen - 2));
        OpMode: begin
          best = 0;
          pick = 0;
          for (int i = 0; i < WinLen; i++) begin
            cnt = 0;
            for (int j = i; j < WinLen; j++) if (w[i] == w[j]) cnt++;
            if (cnt > best) begin
              best = cnt;
              pick = i;
            end
          end
          res = w[pick];
        end
        OpMedian: begin
          for (int i = 1; i < WinLen; i++)
            for (int j = i; j > 0 && w[j-1] > w[j]; j--) begin
              tmp = w[j];
              w[j] = w[j-1];
              w[j-1] = tmp;
            end
          res = w[WinLen/2];
        end
        OpSmooth: begin
          mean = total / longint'(WinLen);
          if (mean > 0) begin
            lim = longint'(threshold) * mean;
            if ((hi - mean) * 256 < lim && (mean - lo) * 256 < lim)
              held_smooth = sample_t'(mean);
          end
          res = held_smooth;
        end
        OpMax: res = sample_t'(hi);
        OpMin: res = sample_t'(lo);
        default: res = '0;
      endcase
      pending_values.push_back(res);
    endfunction

    function void check_result(sample_t got);
      sample_t want;
      if (pending_values.size() == 0) begin
        $display("%0t: unexpected decided_value %0d", $time, got);
        mismatches++;
        return;
      end
      want = pending_values.pop_front();
      if (got !== want) begin
        $display("%0t: decided_value expected %0d actual %0d", $time, want, got);
        mismatches++;
      end
    endfunction
  endclass

  logic            clk_i, rst_ni;
  logic            cfg_we_i;
  logic [ThrW-1:0] cfg_wdata_i;
  logic            in_valid_i, in_ready_o;
  sample_t         sample_i;
  logic [ChW-1:0]  channel_i;
  logic [2:0]      op_i;
  logic            out_valid_o, out_ready_i;
  sample_t         decided_value_o;

  decision_scoreboard board;
  longint unsigned    cycle_count;
  bit                 drain_stalls;

  multichannel_window_decision_filter_unit dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .in_valid_i, .in_ready_o, .sample_i, .channel_i, .op_i,
    .out_valid_o, .out_ready_i, .decided_value_o
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Mostly short gaps, now and then a long one, sometimes none
  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 92) return $urandom_range(1, 4);
    return $urandom_range(20, 120);
  endfunction

  // Accept output beats and stall the receiver at random
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) board.check_result(decided_value_o);
  end

  initial begin
    int unsigned n;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (drain_stalls) out_ready_i <= 1'b1;
      else if (n > 0) begin
        out_ready_i <= 1'b0;
        n--;
      end else begin
        out_ready_i <= 1'b1;
        if ($urandom_range(0, 5) == 0) n = gap_len();
      end
    end
  end

  // Stop a hung run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Send one beat and hold it until accepted; valid stays high until a nonzero idle or a drain drops it
  task automatic send_sample(sample_t smp, logic [ChW-1:0] ch, logic [2:0] op);
    in_valid_i <= 1'b1;
    sample_i   <= smp;
    channel_i  <= ch;
    op_i       <= op;
    do @(posedge clk_i); while (!in_ready_o);
    board.note_sample(smp, ch, op);
  endtask

  task automatic idle_cycles(int unsigned n);
    if (n > 0) in_valid_i <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (board.pending_values.size() != 0) @(posedge clk_i);
    idle_cycles(100);
  endtask

  // Write the threshold while the unit is idle
  task automatic write_threshold(logic [ThrW-1:0] value);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    board.threshold = value;
  endtask

  function automatic sample_t rand_sample(int unsigned kind);
    case (kind)
      0: return sample_t'($urandom());
      1: return sample_t'($urandom_range(0, 16));
      2: return sample_t'($urandom_range(25000, 26000));
      default: return sample_t'($urandom_range(0, 8) - 4);
    endcase
  endfunction

  initial begin
    logic [ThrW-1:0] thr_set[5];
    sample_t         base;
    board = new();
    board.clear_state();
    cycle_count  = 0;
    drain_stalls = 1'b0;
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = '0;
    in_valid_i  = 1'b0;
    sample_i    = '0;
    channel_i   = '0;
    op_i        = '0;
    idle_cycles(10);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: extremes, each op, smooth hold and update, ties, channel fill
    send_sample(sample_t'(24'h7FFFFF), 0, OpMax);
    send_sample(sample_t'(24'h800000), 0, OpMin);
    send_sample(sample_t'(24'h800000), 0, OpTrim);
    send_sample(sample_t'(24'h7FFFFF), 0, OpMedian);
    send_sample(sample_t'(24'hFFFFFF), 1, OpMode);
    send_sample(sample_t'(24'h000001), 1, 3'(OpNone));
    send_sample(sample_t'(24'h555555), 2, 3'(OpZero));
    send_sample(sample_t'(24'hAAAAAA), 3, OpSmooth);
    for (int i = 0; i < WinLen; i++) send_sample(sample_t'(25600 + i), 2, OpSmooth);
    send_sample(sample_t'(-256), 2, OpSmooth);
    send_sample(sample_t'(7), 3, OpMode);
    send_sample(sample_t'(7), 3, OpMedian);
    send_sample(sample_t'(-7), 3, OpTrim);

    thr_set = '{16'hFFFF, 16'd0, 16'd1, 16'd26, 16'd512};
    foreach (thr_set[k]) begin
      write_threshold(thr_set[k]);
      for (int i = 0; i < 250; i++) begin
        idle_cycles(gap_len());
        // Runs of close samples on one channel reach the smooth update path
        if ($urandom_range(0, 2) == 0) begin
          base = rand_sample($urandom_range(1, 2));
          for (int j = 0; j < WinLen && i < 250; j++, i++)
            send_sample(base + sample_t'($urandom_range(0, 40)), 2'(k),
                        $urandom_range(0, 3) == 0 ? 3'($urandom()) : OpSmooth);
        end else begin
          send_sample(rand_sample($urandom_range(0, 3)), 2'($urandom()),
                      3'($urandom()));
        end
        if (k == 2 && i == 100) drain();
      end
    end

    drain_stalls = 1'b1;
    drain();
    if (board.mismatches == 0 && board.pending_values.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule

[multichannel_window_decision_filter_unit.f]
hw/rtl/mwdf_pkg.sv
hw/rtl/mwdf_core.sv
hw/rtl/multichannel_window_decision_filter_unit.sv
hw/rtl/mwdf_checker.sv
verif/multichannel_window_decision_filter_unit_tb.sv
